// ----- rtl/core/mcbb_pkg.sv -----
// Shared types and constants for the material count and bounding box block.
// Used by mcbb_update and material_count_and_bounding_box.
`timescale 1ns / 1ps

package mcbb_pkg;

    localparam int LABEL_BITS  = 8;
    localparam int COORD_BITS  = 12;
    localparam int COUNT_BITS  = 25;
    localparam int TABLE_DEPTH = 1 << LABEL_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
    } entry_t;

    typedef struct packed {
        entry_t                entry;
        logic [COORD_BITS-1:0] extent_x;
        logic [COORD_BITS-1:0] extent_y;
    } result_t;

endpackage

// ----- rtl/core/mcbb_update.sv -----
// Entry update for one cell: saturating count, box widening and extents.
// Pure combinational; depends on mcbb_pkg.
`timescale 1ns / 1ps

module mcbb_update
    import mcbb_pkg::*;
(
    input  entry_t                old_entry,
    input  logic                  old_valid,
    input  logic [COORD_BITS-1:0] cell_x,
    input  logic [COORD_BITS-1:0] cell_y,
    output result_t               result
);

    entry_t new_entry;

    always_comb begin
        if (!old_valid) begin
            // first cell of this label opens the box at its own position
            new_entry.count = COUNT_ONE;
            new_entry.min_x = cell_x;
            new_entry.min_y = cell_y;
            new_entry.max_x = cell_x;
            new_entry.max_y = cell_y;
        end else begin
            new_entry.count = (old_entry.count == COUNT_MAX) ? COUNT_MAX
                                                             : old_entry.count + COUNT_ONE;
            new_entry.min_x = (cell_x < old_entry.min_x) ? cell_x : old_entry.min_x;
            new_entry.min_y = (cell_y < old_entry.min_y) ? cell_y : old_entry.min_y;
            new_entry.max_x = (cell_x > old_entry.max_x) ? cell_x : old_entry.max_x;
            new_entry.max_y = (cell_y > old_entry.max_y) ? cell_y : old_entry.max_y;
        end
    end

    assign result.entry    = new_entry;
    assign result.extent_x = new_entry.max_x - new_entry.min_x;
    assign result.extent_y = new_entry.max_y - new_entry.min_y;

endmodule

// ----- rtl/core/material_count_and_bounding_box.sv -----
// Takes one cell per transfer and returns one result per cell: the label's updated
// count and bounding box with extents. Sustains one cell per clock while the output is
// not stalled by m_ready; the table entry is read into the input stage at the transfer,
// and one update pass loads the result register when that input stage advances.
// The statistics table is a 256-entry single-write, single-read memory with registered
// read; the entry written back by the previous cell is forwarded when the next cell hits
// the same label. Per-label valid flops mark unseen labels, so no clearing pass is
// needed after reset. Depends on mcbb_pkg and mcbb_update.
`timescale 1ns / 1ps

module material_count_and_bounding_box
    import mcbb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_cell_x,
    input  logic [COORD_BITS-1:0] s_cell_y,
    input  logic [LABEL_BITS-1:0] s_material_id,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_BITS-1:0] m_cell_count,
    output logic [COORD_BITS-1:0] m_box_min_x,
    output logic [COORD_BITS-1:0] m_box_min_y,
    output logic [COORD_BITS-1:0] m_box_max_x,
    output logic [COORD_BITS-1:0] m_box_max_y,
    output logic [COORD_BITS-1:0] m_extent_x,
    output logic [COORD_BITS-1:0] m_extent_y
);

    entry_t                 table_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] label_valid_reg;

    logic                  s1_valid_reg;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [LABEL_BITS-1:0] s1_label_reg;
    logic                  s1_hit_reg;
    entry_t                rd_entry_reg;
    entry_t                fwd_entry_reg;

    logic                  m_valid_reg;
    result_t               m_result_reg;

    logic                  s_accept;
    logic                  s1_adv;
    entry_t                old_entry;
    result_t               upd_result;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    assign old_entry = s1_hit_reg ? fwd_entry_reg : rd_entry_reg;

    mcbb_update u_update (
        .old_entry (old_entry),
        .old_valid (label_valid_reg[s1_label_reg]),
        .cell_x    (s1_x_reg),
        .cell_y    (s1_y_reg),
        .result    (upd_result)
    );

    // table write-back and registered read
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            table_mem[s1_label_reg] <= upd_result.entry;
        end
        if (s_accept) begin
            rd_entry_reg <= table_mem[s_material_id];
        end
    end

    // stage 1 payload and forwarding of the entry written on the same edge
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_x_reg      <= s_cell_x;
            s1_y_reg      <= s_cell_y;
            s1_label_reg  <= s_material_id;
            s1_hit_reg    <= s1_adv && (s1_label_reg == s_material_id);
            fwd_entry_reg <= upd_result.entry;
        end
        if (s1_adv) begin
            m_result_reg <= upd_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            label_valid_reg <= '0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_adv) begin
                m_valid_reg                   <= 1'b1;
                label_valid_reg[s1_label_reg] <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_count = m_result_reg.entry.count;
    assign m_box_min_x  = m_result_reg.entry.min_x;
    assign m_box_min_y  = m_result_reg.entry.min_y;
    assign m_box_max_x  = m_result_reg.entry.max_x;
    assign m_box_max_y  = m_result_reg.entry.max_y;
    assign m_extent_x   = m_result_reg.extent_x;
    assign m_extent_y   = m_result_reg.extent_y;

    a_adv_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> m_valid_reg)
        else $error("result not presented after stage advance");

    a_label_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_adv |=> label_valid_reg[$past(s1_label_reg)])
        else $error("label not marked seen after write-back");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_cell_count != '0))
        else $error("result count is zero");

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_box_min_x <= m_box_max_x) && (m_box_min_y <= m_box_max_y))
        else $error("bounding box min exceeds max");

    a_stall_holds_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a full pipeline");

endmodule
